>>> hdl/ppmd_pkg.sv
// Package for the PPM P6 stream decoder: request types, result codes,
// character codes and parse phases. No dependencies.
package ppmd_pkg;

  // Default sizes, handed to the top level's parameters
  localparam int unsigned MAX_DIMENSION_DEF = 1000000;
  localparam int unsigned TOKEN_BUFFER_DEF  = 64;

  // Result queue depth (holds the two results one byte can cause, plus slack)
  localparam int unsigned QDEPTH = 4;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes (the header ones equal the token number that failed)
  localparam logic [2:0] ERR_MAGIC  = 3'd0;
  localparam logic [2:0] ERR_WIDTH  = 3'd1;
  localparam logic [2:0] ERR_HEIGHT = 3'd2;
  localparam logic [2:0] ERR_MAXVAL = 3'd3;
  localparam logic [2:0] ERR_SHORT  = 3'd4;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] MAXVAL_LIMIT = 8'd255;

  // Parse phases
  typedef enum logic [5:0] {
    PH_SKIP         = 6'b000001,
    PH_COMMENT      = 6'b000010,
    PH_TOKEN        = 6'b000100,
    PH_COMMENT_DATA = 6'b001000,
    PH_DATA         = 6'b010000,
    PH_DONE         = 6'b100000
  } phase_t;

  // Input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  // Result request
  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] image_width;
    logic [19:0] image_height;
    logic [7:0]  max_sample;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [2:0]  error_code;
    logic        final_res;
  } out_item_t;

  // Up to two results from one byte, first one always filled first
  typedef struct packed {
    logic      first_vld;
    logic      second_vld;
    out_item_t first;
    out_item_t second;
  } res_pair_t;

endpackage

>>> hdl/ppmd_outq.sv
// Result queue of the PPM P6 stream decoder: takes up to two results a
// cycle, hands one a cycle to the output channel while out_stall is low. Depends on ppmd_pkg.
module ppmd_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  ppmd_pkg::res_pair_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output ppmd_pkg::out_item_t out_data
);

  localparam int unsigned AW = $clog2(ppmd_pkg::QDEPTH);
  localparam int unsigned NW = $clog2(ppmd_pkg::QDEPTH + 1);

  ppmd_pkg::out_item_t mem_r [ppmd_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [AW-1:0] wr_ptr_p1;
  logic          pop;
  logic [NW-1:0] push_n;

  // Room for two more results
  assign room      = count_r <= NW'(ppmd_pkg::QDEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + AW'(1);
  assign push_n    = NW'(push.first_vld) + NW'(push.second_vld);

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push_n);
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + push_n - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write storage
  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.second_vld) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

endmodule

>>> hdl/ppmd_core.sv
// Parser core of the PPM P6 stream decoder: input register, header token
// parser and pixel assembler. Depends on ppmd_pkg.
module ppmd_core #(
  parameter int unsigned MAX_DIMENSION = ppmd_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned TOKEN_BUFFER  = ppmd_pkg::TOKEN_BUFFER_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppmd_pkg::in_item_t  in_data,
  input  logic                room,
  output ppmd_pkg::res_pair_t push
);

  localparam int unsigned VALUE_CAP = (MAX_DIMENSION > 255 ? MAX_DIMENSION : 255) + 1;
  localparam int unsigned VW = $clog2(VALUE_CAP + 1);
  localparam int unsigned XW = VW + 4;
  localparam int unsigned DW = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned CW = $clog2(TOKEN_BUFFER);

  // Input register
  ppmd_pkg::in_item_t item_r;
  logic               in_vld_r;
  logic               take;
  logic               load;

  // Parser state
  ppmd_pkg::phase_t ph_r, ph_nxt;
  logic [1:0]    tn_r, tn_nxt;
  logic [CW-1:0] chars_r, chars_nxt;
  logic [1:0]    magic_r, magic_nxt;
  logic [VW-1:0] nval_r, nval_nxt;
  logic          neg_r, neg_nxt;
  logic          dig_r, dig_nxt;
  logic          stop_r, stop_nxt;
  logic [DW-1:0] wid_r, wid_nxt;
  logic [DW-1:0] hgt_r, hgt_nxt;
  logic [7:0]    maxv_r, maxv_nxt;
  logic [PW-1:0] pix_r, pix_nxt;
  logic [1:0]    comp_r, comp_nxt;
  logic [7:0]    hred_r, hred_nxt;
  logic [7:0]    hgrn_r, hgrn_nxt;

  // Byte classes
  logic [7:0] c;
  logic       eof;
  logic       is_sp;
  logic       is_hash;
  logic       is_lf;
  logic       is_digit;
  logic       is_sign;

  // Character accept
  logic [CW-1:0] ab_chars;
  logic [1:0]    ab_magic;
  logic [VW-1:0] ab_nval;
  logic          ab_neg;
  logic          ab_dig;
  logic          ab_stop;
  logic [CW-1:0] ac_chars;
  logic [1:0]    ac_magic;
  logic [VW-1:0] ac_nval;
  logic          ac_neg;
  logic          ac_dig;
  logic          ac_stop;
  logic [XW-1:0] nv_sum;

  // Step outcome
  ppmd_pkg::phase_t ph1;
  logic [CW-1:0] chars1;
  logic [1:0]    magic1;
  logic [VW-1:0] nval1;
  logic          neg1;
  logic          dig1;
  logic          stop1;
  logic          fin_main;
  logic          do_fin;
  logic          fin_ok;
  logic          dim_ok;
  logic          pix_emit;
  logic          pix_last;
  logic [PW-1:0] pix_dec;
  logic          err_emit;
  logic [2:0]    err_code;
  logic          fin_emit;
  ppmd_pkg::out_item_t res_a;
  ppmd_pkg::out_item_t res_b;

  assign c        = item_r.data_byte;
  assign eof      = item_r.end_of_file;
  assign is_sp    = (c == ppmd_pkg::CH_SPACE) ||
                    (c >= ppmd_pkg::CH_TAB && c <= ppmd_pkg::CH_CR);
  assign is_hash  = c == ppmd_pkg::CH_HASH;
  assign is_lf    = c == ppmd_pkg::CH_LF;
  assign is_digit = c >= ppmd_pkg::CH_ZERO && c <= ppmd_pkg::CH_NINE;
  assign is_sign  = (c == ppmd_pkg::CH_PLUS) || (c == ppmd_pkg::CH_MINUS);

  // Hold a request while the result queue lacks room for two results
  assign take     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (load) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  // Accept one token character; a new token starts from a cleared state
  always_comb begin
    ab_chars = (ph_r == ppmd_pkg::PH_SKIP) ? '0 : chars_r;
    ab_magic = (ph_r == ppmd_pkg::PH_SKIP) ? '0 : magic_r;
    ab_nval  = (ph_r == ppmd_pkg::PH_SKIP) ? '0 : nval_r;
    ab_neg   = (ph_r == ppmd_pkg::PH_SKIP) ? 1'b0 : neg_r;
    ab_dig   = (ph_r == ppmd_pkg::PH_SKIP) ? 1'b0 : dig_r;
    ab_stop  = (ph_r == ppmd_pkg::PH_SKIP) ? 1'b0 : stop_r;
    nv_sum   = (XW'(ab_nval) << 3) + (XW'(ab_nval) << 1) + XW'(c - ppmd_pkg::CH_ZERO);
    ac_chars = ab_chars;
    ac_magic = ab_magic;
    ac_nval  = ab_nval;
    ac_neg   = ab_neg;
    ac_dig   = ab_dig;
    ac_stop  = ab_stop;
    // Drop characters beyond the token buffer
    if (ab_chars < CW'(TOKEN_BUFFER - 1)) begin
      ac_chars = ab_chars + CW'(1);
      if (ab_chars == CW'(0) && c == ppmd_pkg::CH_P && ab_magic == 2'd0) begin
        ac_magic = 2'd1;
      end else if (ab_chars == CW'(1) && c == ppmd_pkg::CH_SIX && ab_magic == 2'd1) begin
        ac_magic = 2'd2;
      end
      if (ab_chars == CW'(0) && is_sign) begin
        ac_neg = ab_neg || (c == ppmd_pkg::CH_MINUS);
      end else if (is_digit && !ab_stop) begin
        ac_nval = (nv_sum > XW'(VALUE_CAP)) ? VW'(VALUE_CAP) : nv_sum[VW-1:0];
        ac_dig  = 1'b1;
      end else begin
        ac_stop = 1'b1;
      end
    end
  end

  // Check the finished token
  assign dim_ok = !stop1 && !neg1 && dig1 && nval1 >= VW'(1) &&
                  nval1 <= VW'(MAX_DIMENSION);

  always_comb begin
    case (tn_r)
      2'd0:    fin_ok = chars1 == CW'(2) && magic1 == 2'd2;
      2'd1:    fin_ok = dim_ok;
      2'd2:    fin_ok = dim_ok;
      default: fin_ok = !neg1 && nval1 >= VW'(1) && nval1 <= VW'(ppmd_pkg::MAXVAL_LIMIT);
    endcase
  end

  // Advance the parser by one byte
  always_comb begin
    ph1      = ph_r;
    chars1   = chars_r;
    magic1   = magic_r;
    nval1    = nval_r;
    neg1     = neg_r;
    dig1     = dig_r;
    stop1    = stop_r;
    fin_main = 1'b0;
    pix_emit = 1'b0;
    pix_dec  = (pix_r != '0) ? pix_r - PW'(1) : pix_r;
    pix_last = pix_dec == '0;
    comp_nxt = comp_r;
    hred_nxt = hred_r;
    hgrn_nxt = hgrn_r;
    pix_nxt  = pix_r;
    unique case (ph_r)
      ppmd_pkg::PH_SKIP: begin
        if (is_hash) begin
          ph1 = ppmd_pkg::PH_COMMENT;
        end else if (!is_sp) begin
          chars1 = ac_chars;
          magic1 = ac_magic;
          nval1  = ac_nval;
          neg1   = ac_neg;
          dig1   = ac_dig;
          stop1  = ac_stop;
          ph1    = ppmd_pkg::PH_TOKEN;
        end
      end
      ppmd_pkg::PH_COMMENT: begin
        if (is_lf) begin
          ph1 = ppmd_pkg::PH_SKIP;
        end
      end
      ppmd_pkg::PH_TOKEN: begin
        if (is_sp || is_hash) begin
          fin_main = 1'b1;
        end else begin
          chars1 = ac_chars;
          magic1 = ac_magic;
          nval1  = ac_nval;
          neg1   = ac_neg;
          dig1   = ac_dig;
          stop1  = ac_stop;
        end
      end
      ppmd_pkg::PH_COMMENT_DATA: begin
        if (is_lf) begin
          ph1 = ppmd_pkg::PH_DATA;
        end
      end
      ppmd_pkg::PH_DATA: begin
        if (comp_r == 2'd0) begin
          hred_nxt = c;
          comp_nxt = 2'd1;
        end else if (comp_r == 2'd1) begin
          hgrn_nxt = c;
          comp_nxt = 2'd2;
        end else begin
          comp_nxt = 2'd0;
          pix_nxt  = pix_dec;
          pix_emit = 1'b1;
          if (pix_last) begin
            ph1 = ppmd_pkg::PH_DONE;
          end
        end
      end
      ppmd_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    // Finish a token on a delimiter, or on end of file inside it
    do_fin    = fin_main || (eof && ph1 == ppmd_pkg::PH_TOKEN);
    ph_nxt    = ph1;
    tn_nxt    = tn_r;
    wid_nxt   = wid_r;
    hgt_nxt   = hgt_r;
    maxv_nxt  = maxv_r;
    fin_emit  = 1'b0;
    if (do_fin) begin
      if (!fin_ok) begin
        fin_emit = 1'b1;
        ph_nxt   = ppmd_pkg::PH_DONE;
      end else if (tn_r == 2'd3) begin
        maxv_nxt = nval1[7:0];
        pix_nxt  = PW'(wid_r) * PW'(hgt_r);
        comp_nxt = 2'd0;
        fin_emit = 1'b1;
        ph_nxt   = (fin_main && is_hash) ? ppmd_pkg::PH_COMMENT_DATA : ppmd_pkg::PH_DATA;
      end else begin
        if (tn_r == 2'd1) begin
          wid_nxt = nval1[DW-1:0];
        end
        if (tn_r == 2'd2) begin
          hgt_nxt = nval1[DW-1:0];
        end
        tn_nxt = tn_r + 2'd1;
        ph_nxt = (fin_main && is_hash) ? ppmd_pkg::PH_COMMENT : ppmd_pkg::PH_SKIP;
      end
    end

    // Build the pixel, header or header error result
    res_a            = '0;
    res_a.image_width  = 20'(wid_nxt);
    res_a.image_height = 20'(hgt_nxt);
    res_a.max_sample   = maxv_nxt;
    if (pix_emit) begin
      res_a.kind      = ppmd_pkg::KIND_PIXEL;
      res_a.red       = hred_r;
      res_a.green     = hgrn_r;
      res_a.blue      = c;
      res_a.alpha     = ppmd_pkg::ALPHA_OPAQUE;
      res_a.final_res = pix_last;
    end else if (fin_ok) begin
      res_a.kind = ppmd_pkg::KIND_HEADER;
    end else begin
      res_a.kind       = ppmd_pkg::KIND_ERROR;
      res_a.error_code = {1'b0, tn_r};
      res_a.final_res  = 1'b1;
    end

    // End of file: report a missing token or short data
    err_emit = 1'b0;
    err_code = ppmd_pkg::ERR_SHORT;
    if (eof) begin
      if (ph_nxt == ppmd_pkg::PH_SKIP || ph_nxt == ppmd_pkg::PH_COMMENT) begin
        err_emit = 1'b1;
        err_code = {1'b0, tn_nxt};
      end else if (ph_nxt == ppmd_pkg::PH_DATA || ph_nxt == ppmd_pkg::PH_COMMENT_DATA) begin
        err_emit = 1'b1;
      end
    end
    res_b              = '0;
    res_b.kind         = ppmd_pkg::KIND_ERROR;
    res_b.image_width  = 20'(wid_nxt);
    res_b.image_height = 20'(hgt_nxt);
    res_b.max_sample   = maxv_nxt;
    res_b.error_code   = err_code;
    res_b.final_res    = 1'b1;
  end

  // Hand results to the queue, packed toward the first slot
  always_comb begin
    push = '0;
    if (take) begin
      if (pix_emit || fin_emit) begin
        push.first_vld  = 1'b1;
        push.first      = res_a;
        push.second_vld = err_emit;
        push.second     = res_b;
      end else begin
        push.first_vld  = err_emit;
        push.first      = res_b;
      end
    end
  end

  // Update state; end of file returns everything to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (take && eof)) begin
      ph_r    <= ppmd_pkg::PH_SKIP;
      tn_r    <= '0;
      chars_r <= '0;
      magic_r <= '0;
      nval_r  <= '0;
      neg_r   <= 1'b0;
      dig_r   <= 1'b0;
      stop_r  <= 1'b0;
      wid_r   <= '0;
      hgt_r   <= '0;
      maxv_r  <= '0;
      pix_r   <= '0;
      comp_r  <= '0;
      hred_r  <= '0;
      hgrn_r  <= '0;
    end else if (take) begin
      ph_r    <= ph_nxt;
      tn_r    <= tn_nxt;
      chars_r <= chars1;
      magic_r <= magic1;
      nval_r  <= nval1;
      neg_r   <= neg1;
      dig_r   <= dig1;
      stop_r  <= stop1;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      maxv_r  <= maxv_nxt;
      pix_r   <= pix_nxt;
      comp_r  <= comp_nxt;
      hred_r  <= hred_nxt;
      hgrn_r  <= hgrn_nxt;
    end
  end

endmodule

>>> hdl/ppm_p6_stream_decoder.sv
// Top level of the PPM P6 stream decoder: parser core and result queue.
// Depends on ppmd_pkg, ppmd_core and ppmd_outq.
//
// Usage: feed the file one byte per request on the in_ channel, with
// end_of_file set on its last byte. The out_ channel returns a header
// result once width, height and maxval are parsed, then one RGBA pixel per
// three data bytes (alpha 255, maxval not applied), or an error result.
// A byte flagged end_of_file puts the parser back in its reset state for
// the next file.
// A result passes the input register, then the result queue, before it
// is valid on out_; while the queue lacks room, the byte waits in the
// input register. Throughput: one byte per cycle while in_stall is low.
// One byte can cause two results; the four-entry result queue absorbs
// them, and in_stall rises only while the queue holds more than two
// results, i.e. while the receiver stalls.
// Reset (rst_n low at a clock edge) empties the queue and input register
// and returns the parser to look for the magic token.
// While out_stall is high the front result holds on out_data.
module ppm_p6_stream_decoder #(
  parameter int unsigned MAX_DIMENSION = ppmd_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned TOKEN_BUFFER  = ppmd_pkg::TOKEN_BUFFER_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppmd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ppmd_pkg::out_item_t out_data
);

  ppmd_pkg::res_pair_t push;
  logic                room;

  // Parse bytes
  ppmd_core #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .TOKEN_BUFFER  (TOKEN_BUFFER)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .push     (push)
  );

  // Queue results toward the receiver
  ppmd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
